@@ rtl/core/odo_pkg.sv @@
package odo_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STEPS  = 24;
  localparam int CHECK_DIVISOR = 1000;

  localparam int CW    = 34;
  localparam int MW    = 64;
  localparam int DW    = 32;
  localparam int IN_W  = 192;
  localparam int OUT_W = 224;
  localparam int IDX_W = 3;
  localparam int AT_IW = 5;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [MW-1:0]        RAD_TO_BAM  = 64'd2935890503282001226;

  localparam logic [IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_WBASE = 3'd1;
  localparam logic [IDX_W-1:0] REG_ORG_X = 3'd2;
  localparam logic [IDX_W-1:0] REG_ORG_Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_ORG_H = 3'd4;

  typedef struct packed {
    logic          start;
    logic [MW-1:0] a;
    logic [MW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic            busy;
    logic [2*MW-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic          start;
    logic [MW-1:0] num;
    logic [DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic [MW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] ang;
  } cor_req_t;

  typedef struct packed {
    logic                 busy;
    logic signed [CW-1:0] cos_v;
    logic signed [CW-1:0] sin_v;
  } cor_rsp_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [CW-1:0] mag_cw(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [MW-1:0] m);
    logic signed [31:0] r;
    if (!neg) begin
      r = (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
    end else begin
      r = (m > 64'h8000_0000) ? 32'sh8000_0000 : $signed(32'd0 - m[31:0]);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_sum(input logic signed [MW-1:0] s);
    logic signed [31:0] r;
    if (s > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (s < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] atan_bam(input logic [AT_IW-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      5'd31: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/odo_mul.sv @@
module odo_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  odo_pkg::mul_req_t req,
  output odo_pkg::mul_rsp_t rsp
);
  import odo_pkg::*;

  localparam int CNT_W = $clog2(MW);

  logic [MW-1:0]    hi_r, hi_nxt, lo_r, lo_nxt, b_r, b_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [MW:0]      acc;

  always_comb begin
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    acc      = {1'b0, hi_r} + (lo_r[0] ? {1'b0, b_r} : '0);
    if (busy_r) begin
      hi_nxt  = acc[MW:1];
      lo_nxt  = {acc[0], lo_r[MW-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(MW - 1)) begin
        busy_nxt = 1'b0;
      end
    end else if (req.start) begin
      hi_nxt   = '0;
      lo_nxt   = req.a;
      b_nxt    = req.b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    b_r  <= b_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.prod = {hi_r, lo_r};

endmodule

@@ rtl/core/odo_div.sv @@
module odo_div (
  input  logic              clk,
  input  logic              rst_n,
  input  odo_pkg::div_req_t req,
  output odo_pkg::div_rsp_t rsp
);
  import odo_pkg::*;

  localparam int CNT_W = $clog2(MW);

  logic [MW-1:0]    q_r, q_nxt;
  logic [DW-1:0]    rem_r, rem_nxt, d_r, d_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DW:0]      trial;
  logic             ge;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, q_r[MW-1]};
    ge       = trial >= {1'b0, d_r};
    if (busy_r) begin
      rem_nxt = ge ? DW'(trial - {1'b0, d_r}) : trial[DW-1:0];
      q_nxt   = {q_r[MW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(MW - 1)) begin
        busy_nxt = 1'b0;
      end
    end else if (req.start) begin
      q_nxt    = req.num;
      rem_nxt  = '0;
      d_nxt    = req.den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.quo  = q_r;

endmodule

@@ rtl/core/odo_cordic.sv @@
module odo_cordic (
  input  logic              clk,
  input  logic              rst_n,
  input  odo_pkg::cor_req_t req,
  output odo_pkg::cor_rsp_t rsp
);
  import odo_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_STEPS + 1);

  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [CW-1:0] dx, dy, at;
  logic                 flip_r, flip_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [31:0]          ang_p, ang_f;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    flip_nxt = flip_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    dx       = y_r >>> cnt_r;
    dy       = x_r >>> cnt_r;
    at       = $signed({2'b00, atan_bam(AT_IW'(cnt_r))});
    ang_p    = req.ang + 32'h4000_0000;
    ang_f    = ang_p[31] ? req.ang + 32'h8000_0000 : req.ang;
    if (busy_r) begin
      if (cnt_r != CNT_W'(CORDIC_STEPS)) begin
        if (!z_r[CW-1]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + at;
        end
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        if (flip_r) begin
          x_nxt = -x_r;
          y_nxt = -y_r;
        end
        busy_nxt = 1'b0;
      end
    end else if (req.start) begin
      flip_nxt = ang_p[31];
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = $signed({{(CW-32){ang_f[31]}}, ang_f});
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
  end

  assign rsp.busy  = busy_r;
  assign rsp.cos_v = x_r;
  assign rsp.sin_v = y_r;

endmodule

@@ rtl/core/wheel_odometry_integrator_core.sv @@
// Channel  Role    Handshake              Payload
// in       sink    in_tvalid / in_tready  in_tdata 192b
// out      source  out_tvalid / out_tready out_tdata 224b, out_tuser 1b
// cfg      sink    cfg_we                 cfg_idx 3b, cfg_data 32b
// One request at a time. The bit-serial multiplier sets the request time: seven
// products in differential mode, nine in Ackermann mode, which also adds up to
// two divides; the CORDIC runs twice per request, three times in Ackermann mode.
// Reset is synchronous; pose loads from the origin registers on the first request.
// A finished result waits in the output register while the next request is taken.
module wheel_odometry_integrator_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // word_a, word_b, word_c, word_d, check_word, elapsed_time
  input  logic [odo_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // pos_x, pos_y, heading_out, vel_x, vel_y, yaw_rate_out, sample_count
  output logic [odo_pkg::OUT_W-1:0]  out_tdata,
  // frame_ok
  output logic                       out_tuser,
  input  logic                       cfg_we,
  input  logic [odo_pkg::IDX_W-1:0]  cfg_idx,
  input  logic [31:0]                cfg_data
);
  import odo_pkg::*;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_CMP    = 5'd1;
  localparam logic [4:0] ST_A_BAM  = 5'd2;
  localparam logic [4:0] ST_A_BAMW = 5'd3;
  localparam logic [4:0] ST_A_TRIG = 5'd4;
  localparam logic [4:0] ST_A_TAN  = 5'd5;
  localparam logic [4:0] ST_A_VT   = 5'd6;
  localparam logic [4:0] ST_A_VTW  = 5'd7;
  localparam logic [4:0] ST_A_OMG  = 5'd8;
  localparam logic [4:0] ST_VDT    = 5'd9;
  localparam logic [4:0] ST_VDTW   = 5'd10;
  localparam logic [4:0] ST_PX     = 5'd11;
  localparam logic [4:0] ST_PY     = 5'd12;
  localparam logic [4:0] ST_ODT    = 5'd13;
  localparam logic [4:0] ST_HD     = 5'd14;
  localparam logic [4:0] ST_HC     = 5'd15;
  localparam logic [4:0] ST_HCW    = 5'd16;
  localparam logic [4:0] ST_VX     = 5'd17;
  localparam logic [4:0] ST_VY     = 5'd18;
  localparam logic [4:0] ST_DONE   = 5'd19;

  logic [4:0]         state_r, state_nxt;
  logic               started_r, started_nxt;
  logic [31:0]        seq_r, seq_nxt;
  logic               mode_r, mode_nxt;
  logic [30:0]        wb_r, wb_nxt;
  logic signed [31:0] org_x_r, org_x_nxt, org_y_r, org_y_nxt;
  logic [31:0]        org_h_r, org_h_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;
  logic               out_user_r, out_user_nxt;

  logic signed [31:0] pose_x_r, pose_x_nxt, pose_y_r, pose_y_nxt;
  logic [31:0]        heading_r, heading_nxt;
  logic signed [CW-1:0] ssum_r, ssum_nxt;
  logic signed [41:0] lo_r, lo_nxt;
  logic               ok_r, ok_nxt;
  logic signed [31:0] wc_r, wc_nxt;
  logic [31:0]        dt_r, dt_nxt;
  logic signed [31:0] v_r, v_nxt, omega_r, omega_nxt, yaw_r, yaw_nxt, tn_r, tn_nxt;
  logic signed [31:0] vx_r, vx_nxt, vy_r, vy_nxt;
  logic               sgn_r, sgn_nxt;
  logic [MW-1:0]      vdt_r, vdt_nxt;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;
  cor_req_t cor_req;
  cor_rsp_t cor_rsp;

  logic signed [31:0] in_a, in_b, in_c, in_d, in_chk;
  logic signed [CW-1:0] sum_w;
  logic signed [41:0] lo_w;
  logic [31:0]        bam_c, bam_h;
  logic [MW-1:0]      pm, vm;
  logic signed [MW-1:0] pd_x, pd_y;

  odo_mul    u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  odo_div    u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
  odo_cordic u_cor (.clk(clk), .rst_n(rst_n), .req(cor_req), .rsp(cor_rsp));

  assign in_a   = $signed(in_tdata[31:0]);
  assign in_b   = $signed(in_tdata[63:32]);
  assign in_c   = $signed(in_tdata[95:64]);
  assign in_d   = $signed(in_tdata[127:96]);
  assign in_chk = $signed(in_tdata[159:128]);
  assign sum_w  = CW'(in_a) + CW'(in_b) + CW'(in_c) + CW'(in_d);
  assign lo_w   = 42'(in_chk) * $signed(42'(CHECK_DIVISOR));

  assign bam_c = mul_rsp.prod[FRAC_BITS+32 +: 32];
  assign bam_h = mul_rsp.prod[2*FRAC_BITS+32 +: 32];
  assign pm    = mul_rsp.prod[FRAC_BITS+30 +: MW];
  assign vm    = mul_rsp.prod[30 +: MW];
  assign pd_x  = MW'(pose_x_r) + (sgn_r ? $signed(MW'(0) - pm) : $signed(pm));
  assign pd_y  = MW'(pose_y_r) + (sgn_r ? $signed(MW'(0) - pm) : $signed(pm));

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    started_nxt   = started_r;
    seq_nxt       = seq_r;
    mode_nxt      = mode_r;
    wb_nxt        = wb_r;
    org_x_nxt     = org_x_r;
    org_y_nxt     = org_y_r;
    org_h_nxt     = org_h_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    pose_x_nxt    = pose_x_r;
    pose_y_nxt    = pose_y_r;
    heading_nxt   = heading_r;
    ssum_nxt      = ssum_r;
    lo_nxt        = lo_r;
    ok_nxt        = ok_r;
    wc_nxt        = wc_r;
    dt_nxt        = dt_r;
    v_nxt         = v_r;
    omega_nxt     = omega_r;
    yaw_nxt       = yaw_r;
    tn_nxt        = tn_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    sgn_nxt       = sgn_r;
    vdt_nxt       = vdt_r;
    mul_req       = '0;
    div_req       = '0;
    cor_req       = '0;

    if (cfg_we) begin
      unique case (cfg_idx)
        REG_MODE:  mode_nxt  = cfg_data[0];
        REG_WBASE: wb_nxt    = cfg_data[30:0];
        REG_ORG_X: org_x_nxt = $signed(cfg_data);
        REG_ORG_Y: org_y_nxt = $signed(cfg_data);
        REG_ORG_H: org_h_nxt = cfg_data;
        default:   ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          wc_nxt    = in_c;
          dt_nxt    = in_tdata[191:160];
          ssum_nxt  = sum_w >>> FRAC_BITS;
          lo_nxt    = lo_w;
          v_nxt     = mode_r ? in_d : in_a;
          omega_nxt = in_b;
          yaw_nxt   = mode_r ? 32'sd0 : in_b;
          if (!started_r) begin
            pose_x_nxt  = org_x_r;
            pose_y_nxt  = org_y_r;
            heading_nxt = org_h_r;
            started_nxt = 1'b1;
          end
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        ok_nxt    = (42'(ssum_r) >= lo_r) &&
                    (42'(ssum_r) < lo_r + $signed(42'(CHECK_DIVISOR)));
        state_nxt = mode_r ? ST_A_BAM : ST_VDT;
      end
      ST_A_BAM: begin
        mul_req.start = 1'b1;
        mul_req.a     = MW'(mag32(wc_r));
        mul_req.b     = RAD_TO_BAM;
        state_nxt     = ST_A_BAMW;
      end
      ST_A_BAMW: begin
        if (!mul_rsp.busy) begin
          cor_req.start = 1'b1;
          cor_req.ang   = wc_r[31] ? 32'd0 - bam_c : bam_c;
          state_nxt     = ST_A_TRIG;
        end
      end
      ST_A_TRIG: begin
        if (!cor_rsp.busy) begin
          if (cor_rsp.cos_v == '0) begin
            tn_nxt    = cor_rsp.sin_v[CW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            state_nxt = ST_A_VT;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = MW'(mag_cw(cor_rsp.sin_v)) << FRAC_BITS;
            div_req.den   = DW'(mag_cw(cor_rsp.cos_v));
            sgn_nxt       = cor_rsp.sin_v[CW-1] ^ cor_rsp.cos_v[CW-1];
            state_nxt     = ST_A_TAN;
          end
        end
      end
      ST_A_TAN: begin
        if (!div_rsp.busy) begin
          tn_nxt    = sat_mag(sgn_r, div_rsp.quo);
          state_nxt = ST_A_VT;
        end
      end
      ST_A_VT: begin
        mul_req.start = 1'b1;
        mul_req.a     = MW'(mag32(v_r));
        mul_req.b     = MW'(mag32(tn_r));
        sgn_nxt       = v_r[31] ^ tn_r[31];
        state_nxt     = ST_A_VTW;
      end
      ST_A_VTW: begin
        if (!mul_rsp.busy) begin
          div_req.start = 1'b1;
          div_req.num   = mul_rsp.prod[MW-1:0];
          div_req.den   = (wb_r == '0) ? DW'(1) : {1'b0, wb_r};
          state_nxt     = ST_A_OMG;
        end
      end
      ST_A_OMG: begin
        if (!div_rsp.busy) begin
          omega_nxt = sat_mag(sgn_r, div_rsp.quo);
          state_nxt = ST_VDT;
        end
      end
      ST_VDT: begin
        mul_req.start = 1'b1;
        mul_req.a     = MW'(mag32(v_r));
        mul_req.b     = MW'(dt_r);
        cor_req.start = 1'b1;
        cor_req.ang   = heading_r;
        state_nxt     = ST_VDTW;
      end
      ST_VDTW: begin
        if (!mul_rsp.busy && !cor_rsp.busy) begin
          vdt_nxt       = mul_rsp.prod[MW-1:0];
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.prod[MW-1:0];
          mul_req.b     = MW'(mag_cw(cor_rsp.cos_v));
          sgn_nxt       = v_r[31] ^ cor_rsp.cos_v[CW-1];
          state_nxt     = ST_PX;
        end
      end
      ST_PX: begin
        if (!mul_rsp.busy) begin
          pose_x_nxt    = sat_sum(pd_x);
          mul_req.start = 1'b1;
          mul_req.a     = vdt_r;
          mul_req.b     = MW'(mag_cw(cor_rsp.sin_v));
          sgn_nxt       = v_r[31] ^ cor_rsp.sin_v[CW-1];
          state_nxt     = ST_PY;
        end
      end
      ST_PY: begin
        if (!mul_rsp.busy) begin
          pose_y_nxt    = sat_sum(pd_y);
          mul_req.start = 1'b1;
          mul_req.a     = MW'(mag32(omega_r));
          mul_req.b     = MW'(dt_r);
          sgn_nxt       = omega_r[31];
          state_nxt     = ST_ODT;
        end
      end
      ST_ODT: begin
        if (!mul_rsp.busy) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.prod[MW-1:0];
          mul_req.b     = RAD_TO_BAM;
          state_nxt     = ST_HD;
        end
      end
      ST_HD: begin
        if (!mul_rsp.busy) begin
          heading_nxt = heading_r + (sgn_r ? 32'd0 - bam_h : bam_h);
          state_nxt   = ST_HC;
        end
      end
      ST_HC: begin
        cor_req.start = 1'b1;
        cor_req.ang   = heading_r;
        state_nxt     = ST_HCW;
      end
      ST_HCW: begin
        if (!cor_rsp.busy) begin
          mul_req.start = 1'b1;
          mul_req.a     = MW'(mag32(v_r));
          mul_req.b     = MW'(mag_cw(cor_rsp.cos_v));
          sgn_nxt       = v_r[31] ^ cor_rsp.cos_v[CW-1];
          state_nxt     = ST_VX;
        end
      end
      ST_VX: begin
        if (!mul_rsp.busy) begin
          vx_nxt        = sat_mag(sgn_r, vm);
          mul_req.start = 1'b1;
          mul_req.a     = MW'(mag32(v_r));
          mul_req.b     = MW'(mag_cw(cor_rsp.sin_v));
          sgn_nxt       = v_r[31] ^ cor_rsp.sin_v[CW-1];
          state_nxt     = ST_VY;
        end
      end
      ST_VY: begin
        if (!mul_rsp.busy) begin
          vy_nxt    = sat_mag(sgn_r, vm);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {seq_r, yaw_r, vy_r, vx_r, heading_r, pose_y_r, pose_x_r};
          out_user_nxt  = ok_r;
          seq_nxt       = seq_r + 32'd1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      seq_r       <= '0;
      mode_r      <= 1'b0;
      wb_r        <= 31'(2) << FRAC_BITS;
      org_x_r     <= '0;
      org_y_r     <= '0;
      org_h_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      seq_r       <= seq_nxt;
      mode_r      <= mode_nxt;
      wb_r        <= wb_nxt;
      org_x_r     <= org_x_nxt;
      org_y_r     <= org_y_nxt;
      org_h_r     <= org_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    pose_x_r   <= pose_x_nxt;
    pose_y_r   <= pose_y_nxt;
    heading_r  <= heading_nxt;
    ssum_r     <= ssum_nxt;
    lo_r       <= lo_nxt;
    ok_r       <= ok_nxt;
    wc_r       <= wc_nxt;
    dt_r       <= dt_nxt;
    v_r        <= v_nxt;
    omega_r    <= omega_nxt;
    yaw_r      <= yaw_nxt;
    tn_r       <= tn_nxt;
    vx_r       <= vx_nxt;
    vy_r       <= vy_nxt;
    sgn_r      <= sgn_nxt;
    vdt_r      <= vdt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ rtl/core/odo_checker.sv @@
module odo_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [odo_pkg::OUT_W-1:0] out_tdata,
  input logic                      out_tuser
);
  import odo_pkg::*;

  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind wheel_odometry_integrator_core odo_checker u_odo_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import odo_pkg::*;

  localparam longint CHK_DIV   = 64'sd65536000;
  localparam longint CYCLE_CAP = 20000000;

  typedef struct {
    logic [31:0] px, py, hd, vx, vy, yw, cnt;
    logic        ok;
  } pose_res_t;

  class pose_tracker;
    logic [31:0] atan_tab[24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    logic        ack_mode;
    logic [30:0] wbase;
    logic [31:0] org_x, org_y, org_h;
    longint      px, py;
    logic [31:0] hd, seq;
    bit          started;
    pose_res_t   expected_poses[$];
    int          errors;

    function new();
      ack_mode = 0; wbase = 31'd131072; org_x = 0; org_y = 0; org_h = 0;
      px = 0; py = 0; hd = 0; seq = 0; started = 0; errors = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_MODE:  ack_mode = val[0];
        REG_WBASE: wbase = val[30:0];
        REG_ORG_X: org_x = val;
        REG_ORG_Y: org_y = val;
        REG_ORG_H: org_h = val;
        default: ;
      endcase
    endfunction

    function logic [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return 64'(p >> s);
    endfunction

    function longint scale_signed(longint a, longint b, int s);
      logic [63:0] m;
      m = mul_shift(mag(a), mag(b), s);
      if (m > 64'h7FFF_FFFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF_FFFF;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function logic [31:0] rad_to_bam(longint r, int frac);
      logic [31:0] u;
      u = 32'(mul_shift(mag(r), RAD_TO_BAM, frac + 32));
      return r < 0 ? 32'd0 - u : u;
    endfunction

    function void rotate(logic [31:0] ang, output longint c, output longint s);
      bit     flip;
      longint x, y, z, dx, dy;
      logic [31:0] t;
      t = ang + 32'h40000000;
      flip = t[31];
      if (flip) ang = ang + 32'h80000000;
      z = longint'($signed(ang));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_tab[i]);
        end else begin
          x += dx; y -= dy; z += longint'(atan_tab[i]);
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      c = x;
      s = y;
    endfunction

    function longint check_of(longint a, longint b, longint c, longint d);
      longint sum, q;
      sum = a + b + c + d;
      q = sum / CHK_DIV;
      if (sum % CHK_DIV != 0 && sum < 0) q--;
      return q;
    endfunction

    function void note_sample(logic [IN_W-1:0] d);
      longint    a, b, c, w4, chk, dt, v, om, yw, sc, ss, tn, lb, vdt, co, si;
      pose_res_t r;
      a   = longint'($signed(d[31:0]));
      b   = longint'($signed(d[63:32]));
      c   = longint'($signed(d[95:64]));
      w4  = longint'($signed(d[127:96]));
      chk = longint'($signed(d[159:128]));
      dt  = longint'({32'd0, d[191:160]});
      if (!started) begin
        px = longint'($signed(org_x));
        py = longint'($signed(org_y));
        hd = org_h;
        started = 1;
      end
      r.ok = (check_of(a, b, c, w4) == chk);
      if (!ack_mode) begin
        v = a; om = b; yw = b;
      end else begin
        v = w4;
        rotate(rad_to_bam(c, FRAC_BITS), sc, ss);
        if (sc == 0) tn = ss >= 0 ? 64'sd2147483647 : -64'sd2147483648;
        else tn = sat32((ss * 65536) / sc);
        lb = longint'({33'd0, wbase});
        if (lb == 0) lb = 1;
        om = sat32((v * tn) / lb);
        yw = 0;
      end
      vdt = v * dt;
      rotate(hd, co, si);
      px = sat32(px + scale_signed(vdt, co, FRAC_BITS + 30));
      py = sat32(py + scale_signed(vdt, si, FRAC_BITS + 30));
      hd = hd + rad_to_bam(om * dt, 2 * FRAC_BITS);
      rotate(hd, co, si);
      r.px = px[31:0];
      r.py = py[31:0];
      r.hd = hd;
      r.vx = 32'(sat32(scale_signed(v, co, 30)));
      r.vy = 32'(sat32(scale_signed(v, si, 30)));
      r.yw = yw[31:0];
      r.cnt = seq;
      seq++;
      expected_poses.push_back(r);
    endfunction

    function void cmp(string f, logic [31:0] e, logic [31:0] g);
      if (e !== g) begin
        errors++;
        $display("%0t %s mismatch: expected %h actual %h", $time, f, e, g);
      end
    endfunction

    function void check_pose(logic [OUT_W-1:0] t, logic u);
      pose_res_t e;
      if (expected_poses.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %h", $time, t);
        return;
      end
      e = expected_poses.pop_front();
      cmp("pos_x", e.px, t[31:0]);
      cmp("pos_y", e.py, t[63:32]);
      cmp("heading", e.hd, t[95:64]);
      cmp("vel_x", e.vx, t[127:96]);
      cmp("vel_y", e.vy, t[159:128]);
      cmp("yaw_rate", e.yw, t[191:160]);
      cmp("sample_count", e.cnt, t[223:192]);
      cmp("frame_ok", {31'd0, e.ok}, {31'd0, u});
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_tvalid = 0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 0;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tuser;
  logic              cfg_we = 0;
  logic [IDX_W-1:0]  cfg_idx = '0;
  logic [31:0]       cfg_data = '0;

  pose_tracker tracker = new();
  longint      cycles = 0;
  int          stall_left = 0;
  bit          quiet = 0;

  wheel_odometry_integrator_core dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb failed");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) tracker.check_pose(out_tdata, out_tuser);
  end

  always @(negedge clk) begin
    int r;
    if (quiet) begin
      out_tready <= 1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        out_tready <= 1;
      end else begin
        stall_left = (r < 95) ? $urandom_range(0, 4) : $urandom_range(20, 300);
        out_tready <= 0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 5);
    return $urandom_range(50, 1200);
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_idx = idx;
    cfg_data = val;
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 0;
    wait (tracker.expected_poses.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic send(logic [31:0] a, b, c, d, chk, dt);
    int g;
    @(negedge clk);
    in_tvalid = 1;
    in_tdata = {dt, chk, d, c, b, a};
    do @(posedge clk); while (!in_tready);
    tracker.note_sample(in_tdata);
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_tvalid = 0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send_ok(logic [31:0] a, b, c, d, dt);
    longint q;
    q = tracker.check_of($signed(a), $signed(b), $signed(c), $signed(d));
    send(a, b, c, d, q[31:0], dt);
  endtask

  function automatic logic [31:0] rnd_s(int lim);
    return 32'($urandom_range(0, 2 * lim) - lim);
  endfunction

  task automatic random_burst(int n);
    logic [31:0] a, b, c, d, dt;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        a = rnd_s(32'h100000); b = rnd_s(32'h40000);
        c = rnd_s(32'h18000); d = rnd_s(32'h100000);
        dt = $urandom_range(0, 32'h2000);
        if ($urandom_range(0, 9) == 0) send(a, b, c, d, $urandom, dt);
        else send_ok(a, b, c, d, dt);
      end else if (r < 92) begin
        send_ok($urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        send($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      if (i % 97 == 0) quiet = ~quiet;
    end
    quiet = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    write_reg(REG_MODE, 32'd0);
    write_reg(REG_WBASE, 32'h7FFFFFFF);
    write_reg(REG_ORG_X, 32'h0012_3456);
    write_reg(REG_ORG_Y, 32'hFFF0_0000);
    write_reg(REG_ORG_H, 32'hC000_0000);

    send_ok(0, 0, 0, 0, 0);
    send_ok(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_ok(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'hFFFFFFFF);
    send(32'h10000, 32'h8000, 32'h1, 32'h2, 32'd5, 32'h10000);
    send_ok(32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0001_0000);
    send_ok(32'h0001_0000, 32'h7FFFFFFF, 32'h0, 32'h0, 32'hFFFFFFFF);
    send_ok(32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 32'h7FFF_0000);
    send_ok(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h1);
    drain();

    // origin writes after the first request must not move the pose
    write_reg(REG_ORG_X, 32'h7FFFFFFF);
    write_reg(REG_ORG_Y, 32'h80000000);
    write_reg(REG_ORG_H, 32'hFFFFFFFF);
    write_reg(REG_MODE, 32'd1);
    send_ok(0, 0, 32'd102944, 32'h10000, 32'h10000);
    send_ok(0, 0, 32'hFFFE6DE0, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_ok(0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h10000);
    send_ok(0, 0, 32'h80000000, 32'h10000, 32'h10000);
    send(32'h5, 32'h6, 32'h8000, 32'h20000, 32'h80000000, 32'h4000);
    drain();
    write_reg(REG_WBASE, 32'd0);
    send_ok(0, 0, 32'h8000, 32'h7FFFFFFF, 32'h10000);
    send_ok(0, 0, 32'hFFFF8000, 32'h80000000, 32'hFFFFFFFF);
    drain();
    write_reg(REG_WBASE, 32'd1);
    send_ok(0, 0, 32'h4000, 32'h10000, 32'h100);
    random_burst(300);
    drain();

    write_reg(REG_WBASE, 32'd131072);
    random_burst(400);
    // hold the sender until every result is back
    drain();
    random_burst(100);
    drain();
    write_reg(REG_MODE, 32'd0);
    write_reg(REG_WBASE, $urandom_range(1, 32'h7FFFFFFF));
    random_burst(600);
    drain();
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_WBASE, 32'h7FFFFFFF);
    random_burst(300);
    drain();
    write_reg(REG_MODE, 32'd0);
    random_burst(250);

    @(negedge clk);
    in_tvalid = 0;
    wait (tracker.expected_poses.size() == 0);
    repeat (1000) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
